@@ sv/mpm_pkg.sv @@
`default_nettype none

package mpm_pkg;

    // Width of the internal time base; now_ms is truncated or zero-extended to it.
    localparam int TIME_WIDTH = 32;

    typedef logic [TIME_WIDTH-1:0] t_time;

    // door motion codes
    localparam logic [1:0] MOTION_IDLE    = 2'd0;
    localparam logic [1:0] MOTION_OPENING = 2'd1;
    localparam logic [1:0] MOTION_CLOSING = 2'd2;

    // result action codes
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_NO_CURRENT = 3'd1;
    localparam logic [2:0] ACT_NO_PULSES  = 3'd2;
    localparam logic [2:0] ACT_OPEN_END   = 3'd3;
    localparam logic [2:0] ACT_CLOSED_END = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_CURRENT  = 3'd0;
    localparam logic [2:0] CFG_ZC_TIMEOUT   = 3'd1;
    localparam logic [2:0] CFG_ENC_TIMEOUT  = 3'd2;
    localparam logic [2:0] CFG_MIN_PULSES   = 3'd3;
    localparam logic [2:0] CFG_CHECK_PERIOD = 3'd4;
    localparam logic [2:0] CFG_BLANKING     = 3'd5;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [1:0]         door_motion;
        logic [15:0]        current_ma;
        logic signed [31:0] encoder_count;
        logic               encoder_enabled;
        logic               near_open;
        logic               near_closed;
    } t_sample;

    typedef struct packed {
        logic [2:0] action;
        logic       checked;
    } t_result;

endpackage

`default_nettype wire

@@ sv/motor_plausibility_monitor.sv @@
`default_nettype none

// Channel  | Dir | Signals                              | Request
// ---------+-----+--------------------------------------+-----------------------
// sample   | in  | i_in_valid, o_in_stall, i_in         | one sensor sample
// result   | out | o_out_valid, i_out_stall, o_out      | action + checked flag
// config   | in  | i_cfg_we, i_cfg_idx, i_cfg_data      | 16-bit register write
//
// Two register stages: input register, then result register. The check logic
// between them is a handful of wrapping subtracts and compares, so one request
// is taken each cycle without a result-side stall; o_out_valid is registered.
// Synchronous active-low reset restores the default thresholds and clears all
// supervision state. A stall on the result side holds the result register and,
// through the input register, backs up into o_in_stall in the same cycle.

module motor_plausibility_monitor (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mpm_pkg::t_sample   i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mpm_pkg::t_result        o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data
);

    // configuration
    logic [15:0] r_min_current;
    logic [15:0] r_zc_timeout;
    logic [15:0] r_enc_timeout;
    logic [15:0] r_min_pulses;
    logic [15:0] r_check_period;
    logic [15:0] r_blanking;

    // pipeline
    logic              r_in_valid;
    mpm_pkg::t_sample  r_in;
    logic              r_out_valid;
    mpm_pkg::t_result  r_out;
    logic              adv;

    // supervision state
    mpm_pkg::t_time r_last_check;
    logic [31:0]    r_prev_count;
    mpm_pkg::t_time r_zc_start;
    logic           r_zc_active;
    mpm_pkg::t_time r_pw_start;
    logic           r_pw_active;
    logic [31:0]    r_pw_total;
    mpm_pkg::t_time r_ms_start;
    logic           r_ms_valid;

    mpm_pkg::t_time   n_last_check;
    logic [31:0]      n_prev_count;
    mpm_pkg::t_time   n_zc_start;
    logic             n_zc_active;
    mpm_pkg::t_time   n_pw_start;
    logic             n_pw_active;
    logic [31:0]      n_pw_total;
    mpm_pkg::t_time   n_ms_start;
    logic             n_ms_valid;
    mpm_pkg::t_result n_out;

    // combinational helpers
    mpm_pkg::t_time now;
    mpm_pkg::t_time ms_eff;
    mpm_pkg::t_time zc_eff;
    mpm_pkg::t_time pw_eff;
    logic           moving;
    logic           low_current;
    logic [31:0]    enc;
    logic [31:0]    step;
    logic [31:0]    mag;
    logic [31:0]    total_base;
    logic [32:0]    total_sum;
    logic [31:0]    total_new;

    // the result register frees when empty or taken
    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_current  <= 16'd150;
            r_zc_timeout   <= 16'd800;
            r_enc_timeout  <= 16'd700;
            r_min_pulses   <= 16'd2;
            r_check_period <= 16'd50;
            r_blanking     <= 16'd500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mpm_pkg::CFG_MIN_CURRENT:  r_min_current  <= i_cfg_data;
                mpm_pkg::CFG_ZC_TIMEOUT:   r_zc_timeout   <= i_cfg_data;
                mpm_pkg::CFG_ENC_TIMEOUT:  r_enc_timeout  <= i_cfg_data;
                mpm_pkg::CFG_MIN_PULSES:   r_min_pulses   <= i_cfg_data;
                mpm_pkg::CFG_CHECK_PERIOD: r_check_period <= i_cfg_data;
                mpm_pkg::CFG_BLANKING:     r_blanking     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    // check logic on the registered sample
    always_comb begin
        now         = mpm_pkg::t_time'(r_in.now_ms);
        enc         = r_in.encoder_count;
        moving      = (r_in.door_motion == mpm_pkg::MOTION_OPENING) ||
                      (r_in.door_motion == mpm_pkg::MOTION_CLOSING);
        low_current = r_in.current_ma <= r_min_current;

        ms_eff = r_ms_valid  ? r_ms_start : now;
        zc_eff = r_zc_active ? r_zc_start : now;
        pw_eff = r_pw_active ? r_pw_start : now;

        // signed step magnitude, 2^31 fits unsigned
        step       = enc - r_prev_count;
        mag        = step[31] ? (32'd0 - step) : step;
        total_base = r_pw_active ? r_pw_total : 32'd0;
        total_sum  = {1'b0, total_base} + {1'b0, mag};
        total_new  = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

        n_last_check = r_last_check;
        n_prev_count = r_prev_count;
        n_zc_start   = r_zc_start;
        n_zc_active  = r_zc_active;
        n_pw_start   = r_pw_start;
        n_pw_active  = r_pw_active;
        n_pw_total   = r_pw_total;
        n_ms_start   = r_ms_start;
        n_ms_valid   = r_ms_valid;
        n_out.action  = mpm_pkg::ACT_NONE;
        n_out.checked = 1'b0;

        if ((now - r_last_check) >= mpm_pkg::t_time'(r_check_period)) begin
            n_last_check  = now;
            n_out.checked = 1'b1;
            n_prev_count  = enc;   // every evaluated path leaves the count here

            if (!moving) begin
                n_zc_active = 1'b0;
                n_zc_start  = '0;
                n_pw_active = 1'b0;
                n_pw_start  = '0;
                n_pw_total  = '0;
                n_ms_valid  = 1'b0;
                n_ms_start  = '0;
            end else begin
                n_ms_start = ms_eff;
                n_ms_valid = 1'b1;

                if (low_current) begin
                    // zero-current check past blanking
                    if ((now - ms_eff) > mpm_pkg::t_time'(r_blanking)) begin
                        n_zc_start  = zc_eff;
                        n_zc_active = 1'b1;
                        if ((now - zc_eff) >= mpm_pkg::t_time'(r_zc_timeout)) begin
                            n_out.action = mpm_pkg::ACT_NO_CURRENT;
                            n_zc_active  = 1'b0;
                            n_zc_start   = '0;
                            n_pw_active  = 1'b0;
                            n_pw_start   = '0;
                            n_pw_total   = '0;
                        end
                    end
                end else begin
                    n_zc_active = 1'b0;
                    n_zc_start  = '0;
                    if (r_in.encoder_enabled) begin
                        if (total_new >= {16'd0, r_min_pulses}) begin
                            n_pw_active = 1'b0;
                            n_pw_start  = '0;
                            n_pw_total  = '0;
                        end else if ((now - pw_eff) >=
                                     mpm_pkg::t_time'(r_enc_timeout)) begin
                            if (r_in.door_motion == mpm_pkg::MOTION_OPENING &&
                                r_in.near_open) begin
                                n_out.action = mpm_pkg::ACT_OPEN_END;
                            end else if (r_in.door_motion == mpm_pkg::MOTION_CLOSING &&
                                         r_in.near_closed) begin
                                n_out.action = mpm_pkg::ACT_CLOSED_END;
                            end else begin
                                n_out.action = mpm_pkg::ACT_NO_PULSES;
                            end
                            n_pw_active = 1'b0;
                            n_pw_start  = '0;
                            n_pw_total  = '0;
                        end else begin
                            n_pw_active = 1'b1;
                            n_pw_start  = pw_eff;
                            n_pw_total  = total_new;
                        end
                    end
                end
            end
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_check <= '0;
            r_prev_count <= '0;
            r_zc_start   <= '0;
            r_zc_active  <= 1'b0;
            r_pw_start   <= '0;
            r_pw_active  <= 1'b0;
            r_pw_total   <= '0;
            r_ms_start   <= '0;
            r_ms_valid   <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_last_check <= n_last_check;
                r_prev_count <= n_prev_count;
                r_zc_start   <= n_zc_start;
                r_zc_active  <= n_zc_active;
                r_pw_start   <= n_pw_start;
                r_pw_active  <= n_pw_active;
                r_pw_total   <= n_pw_total;
                r_ms_start   <= n_ms_start;
                r_ms_valid   <= n_ms_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // any reported action comes from an evaluated sample
    a_action_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.action != mpm_pkg::ACT_NONE) |-> r_out.checked)
        else $error("action reported on an unchecked sample");

    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.action <= mpm_pkg::ACT_CLOSED_END))
        else $error("action code out of range");

    // back-pressure only when the input register holds a request
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with free pipeline");

    // inactive markers always carry a cleared start time
    a_zc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_zc_active |-> (r_zc_start == '0))
        else $error("zero-current start left set while inactive");

    a_pw_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pw_active |-> (r_pw_start == '0) && (r_pw_total == '0))
        else $error("pulse window left set while inactive");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;

    // Stimulus shapes for one door movement.
    localparam int PLOT_HEALTHY      = 0;   // current present, encoder advancing
    localparam int PLOT_DEAD_CURRENT = 1;   // current at or below threshold
    localparam int PLOT_JAMMED       = 2;   // current present, encoder (almost) stuck
    localparam int PLOT_MIXED        = 3;   // a new pick for every sample

    // Stall modes of the result side.
    localparam int SINK_FREE      = 0;
    localparam int SINK_SPARSE    = 1;
    localparam int SINK_ALTERNATE = 2;
    localparam int SINK_HEAVY     = 3;

    localparam int QUIET_LIMIT = 3000;      // cycles without any handshake
    localparam int SETTLE_CYCLES = 4;       // two-stage pipe plus margin

    logic    i_clk = 1'b0;
    logic    rst_n = 1'b0;

    logic             in_valid = 1'b0;
    mpm_pkg::t_sample in_bus = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic             out_stall = 1'b0;
    mpm_pkg::t_result o_out;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = mpm_pkg::CFG_MIN_CURRENT;
    logic [15:0] cfg_data = '0;

    motor_plausibility_monitor dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (in_bus),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out      (o_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: thresholds as last written, supervision state.
    // ------------------------------------------------------------------
    logic [15:0] cfg_val [0:5] = '{16'd150, 16'd800, 16'd700, 16'd2, 16'd50, 16'd500};

    logic [31:0] last_check    = '0;
    logic [31:0] prev_count    = '0;
    logic [31:0] zc_since      = '0;
    logic        zc_armed      = 1'b0;
    logic [31:0] window_since  = '0;
    logic        window_armed  = 1'b0;
    logic [31:0] step_total    = '0;
    logic [31:0] move_since    = '0;
    logic        move_armed    = 1'b0;

    mpm_pkg::t_sample sample_queue [$];   // samples waiting to be offered
    mpm_pkg::t_result due_verdicts [$];   // verdicts owed by the block, oldest first

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int n_samples      = 0;
    int n_verdicts     = 0;
    int n_checked      = 0;
    int n_settings     = 1;
    int act_tally [0:7] = '{default: 0};

    logic        in_took = 1'b0;
    logic [31:0] sim_ms  = '0;
    logic [31:0] enc_pos = '0;

    // Both markers, the step total and the encoder baseline are reset
    // together on idle and after every reported action.
    function automatic void drop_markers(input logic [31:0] enc);
        zc_armed     = 1'b0;
        zc_since     = '0;
        window_armed = 1'b0;
        window_since = '0;
        step_total   = '0;
        prev_count   = enc;
    endfunction

    // Verdict for one sample; advances the shadow state.
    function automatic mpm_pkg::t_result judge_sample(input mpm_pkg::t_sample s);
        mpm_pkg::t_result r;
        logic [31:0]      diff;
        logic [31:0]      mag;
        logic [32:0]      sum;
        logic             low;
        r.action  = mpm_pkg::ACT_NONE;
        r.checked = 1'b0;

        // everything is a wrapping unsigned difference
        if (s.now_ms - last_check < cfg_val[mpm_pkg::CFG_CHECK_PERIOD])
            return r;
        last_check = s.now_ms;
        r.checked  = 1'b1;

        // idle, and the unused motion code, flush everything
        if (s.door_motion != mpm_pkg::MOTION_OPENING &&
            s.door_motion != mpm_pkg::MOTION_CLOSING) begin
            drop_markers(s.encoder_count);
            move_armed = 1'b0;
            move_since = '0;
            return r;
        end

        if (!move_armed) begin
            move_since = s.now_ms;
            move_armed = 1'b1;
        end

        low = s.current_ma <= cfg_val[mpm_pkg::CFG_MIN_CURRENT];

        if (low) begin
            // zero-current timer only runs once the start blanking is over
            if (s.now_ms - move_since > cfg_val[mpm_pkg::CFG_BLANKING]) begin
                if (!zc_armed) begin
                    zc_since = s.now_ms;
                    zc_armed = 1'b1;
                end
                if (s.now_ms - zc_since >= cfg_val[mpm_pkg::CFG_ZC_TIMEOUT]) begin
                    r.action = mpm_pkg::ACT_NO_CURRENT;
                    drop_markers(s.encoder_count);
                    return r;
                end
            end
        end else begin
            zc_armed = 1'b0;
            zc_since = '0;
        end

        if (s.encoder_enabled && !low) begin
            diff = s.encoder_count - prev_count;
            mag  = diff[31] ? -diff : diff;     // 0x8000_0000 stays 2^31
            if (!window_armed) begin
                window_since = s.now_ms;
                window_armed = 1'b1;
                step_total   = '0;
            end
            sum        = {1'b0, step_total} + {1'b0, mag};
            step_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

            if (step_total >= cfg_val[mpm_pkg::CFG_MIN_PULSES]) begin
                window_armed = 1'b0;
                window_since = '0;
                step_total   = '0;
            end else if (s.now_ms - window_since >=
                         cfg_val[mpm_pkg::CFG_ENC_TIMEOUT]) begin
                // stuck encoder: end stop if heading into the near end
                if (s.door_motion == mpm_pkg::MOTION_OPENING && s.near_open)
                    r.action = mpm_pkg::ACT_OPEN_END;
                else if (s.door_motion == mpm_pkg::MOTION_CLOSING && s.near_closed)
                    r.action = mpm_pkg::ACT_CLOSED_END;
                else
                    r.action = mpm_pkg::ACT_NO_PULSES;
                drop_markers(s.encoder_count);
                return r;
            end
        end

        prev_count = s.encoder_count;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want,
                 n_verdicts);
    endtask

    // ------------------------------------------------------------------
    // Sample-side driver: bursts of random length with random gaps.
    // A held request keeps its payload until the block takes it.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin : feeder
        logic             nxt_valid;
        mpm_pkg::t_sample nxt_bus;
        nxt_valid = 1'b0;
        nxt_bus   = in_bus;
        if (in_valid && !in_took) begin
            nxt_valid = 1'b1;
        end else begin
            if (in_took)
                sample_queue.delete(0);
            if (gap_left > 0) begin
                gap_left--;
            end else if (sample_queue.size() > 0) begin
                nxt_valid = 1'b1;
                nxt_bus   = sample_queue[0];
                if (burst_left <= 1) begin
                    // now and then a long stretch with no gaps at all
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 40);
                    gap_left   = $urandom_range(0, 6);
                end else begin
                    burst_left--;
                end
            end
        end
        in_valid <= nxt_valid;
        in_bus   <= nxt_bus;
    end

    // Result-side stall: switches between a few patterns of its own.
    int sink_mode = SINK_FREE;
    int sink_left = 0;

    always @(negedge i_clk) begin : sink
        logic nxt_stall;
        if (sink_left == 0) begin
            sink_mode = $urandom_range(SINK_FREE, SINK_HEAVY);
            sink_left = $urandom_range(5, 60);
        end
        sink_left--;
        case (sink_mode)
            SINK_SPARSE:    nxt_stall = ($urandom_range(0, 2) == 0);
            SINK_ALTERNATE: nxt_stall = ~out_stall;
            SINK_HEAVY:     nxt_stall = ($urandom_range(0, 3) != 0);
            default:        nxt_stall = 1'b0;
        endcase
        out_stall <= nxt_stall;
    end

    // ------------------------------------------------------------------
    // Monitor: scores both handshakes at the rising edge, pre-update values.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        mpm_pkg::t_result want;
        if (rst_n) begin
            quiet_cycles++;
            if (in_valid && !o_in_stall) begin
                due_verdicts.push_back(judge_sample(in_bus));
                n_samples++;
                quiet_cycles = 0;
            end
            if (o_out_valid && !out_stall) begin
                quiet_cycles = 0;
                n_verdicts++;
                if (o_out.checked)
                    n_checked++;
                act_tally[o_out.action]++;
                if (due_verdicts.size() == 0) begin
                    note_mismatch("unrequested result, action",
                                  longint'(o_out.action), longint'(-1));
                end else begin
                    want = due_verdicts.pop_front();
                    if (o_out.action !== want.action)
                        note_mismatch("action", longint'(o_out.action),
                                      longint'(want.action));
                    if (o_out.checked !== want.checked)
                        note_mismatch("checked", longint'(o_out.checked),
                                      longint'(want.checked));
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results owed",
                         QUIET_LIMIT, due_verdicts.size());
                $display("Some tests failed");
                $finish;
            end
        end
        in_took <= rst_n && in_valid && !o_in_stall;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_sample(input logic [31:0] t, input logic [1:0] mo,
                               input logic [15:0] cur, input logic [31:0] enc,
                               input logic en, input logic nopen, input logic nclosed);
        mpm_pkg::t_sample s;
        s.now_ms          = t;
        s.door_motion     = mo;
        s.current_ma      = cur;
        s.encoder_count   = enc;
        s.encoder_enabled = en;
        s.near_open       = nopen;
        s.near_closed     = nclosed;
        sample_queue.push_back(s);
    endtask

    // Time steps scale with the period and the timeouts so that a movement
    // of a few dozen samples can run into every timeout.
    function automatic logic [31:0] next_ms();
        int unsigned base;
        int unsigned r;
        logic [31:0] stride;
        base = cfg_val[mpm_pkg::CFG_CHECK_PERIOD];
        if ((cfg_val[mpm_pkg::CFG_BLANKING] + cfg_val[mpm_pkg::CFG_ZC_TIMEOUT]) / 6 > base)
            base = (cfg_val[mpm_pkg::CFG_BLANKING] + cfg_val[mpm_pkg::CFG_ZC_TIMEOUT]) / 6;
        if (cfg_val[mpm_pkg::CFG_ENC_TIMEOUT] / 6 > base)
            base = cfg_val[mpm_pkg::CFG_ENC_TIMEOUT] / 6;
        if (base == 0)
            base = 1;
        r = $urandom_range(0, 99);
        if (r < 8)
            stride = $urandom_range(0, cfg_val[mpm_pkg::CFG_CHECK_PERIOD]);  // often skipped
        else if (r < 11)
            stride = $urandom;                                       // jump, may wrap
        else
            stride = base + $urandom_range(0, base / 2 + 3);
        sim_ms = sim_ms + stride;
        return sim_ms;
    endfunction

    function automatic logic [15:0] live_current();
        int unsigned mc;
        int unsigned top;
        mc = cfg_val[mpm_pkg::CFG_MIN_CURRENT];
        if (mc == 16'hFFFF)
            return 16'hFFFF;            // threshold at the top: always "zero"
        top = ($urandom_range(0, 3) == 0 || mc + 400 > 65535) ? 65535 : mc + 400;
        return 16'($urandom_range(mc + 1, top));
    endfunction

    task automatic queue_motion(input logic [1:0] mo, input int plot);
        int          kind;
        logic [15:0] cur;
        int unsigned mag;
        logic [31:0] t;
        kind = (plot == PLOT_MIXED) ? $urandom_range(PLOT_HEALTHY, PLOT_JAMMED) : plot;
        t    = next_ms();
        case (kind)
            PLOT_HEALTHY: begin
                cur = live_current();
                mag = cfg_val[mpm_pkg::CFG_MIN_PULSES] + $urandom_range(0, 3);
            end
            PLOT_DEAD_CURRENT: begin
                cur = ($urandom_range(0, 3) == 0) ? cfg_val[mpm_pkg::CFG_MIN_CURRENT]
                    : 16'($urandom_range(0, cfg_val[mpm_pkg::CFG_MIN_CURRENT]));
                mag = $urandom_range(0, 2);
            end
            default: begin
                cur = live_current();
                mag = ($urandom_range(0, 4) == 0) ? 1 : 0;
            end
        endcase
        if ($urandom_range(0, 1))
            enc_pos = enc_pos + mag;
        else
            enc_pos = enc_pos - mag;
        if ($urandom_range(0, 49) == 0)
            enc_pos = $urandom;
        push_sample(t, mo, cur, enc_pos, $urandom_range(0, 15) != 0,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Mostly whole movements (idle lead-in, then one shaped movement),
    // the rest fully random samples.
    task automatic queue_traffic(input int count);
        int          left;
        int          k;
        int          len;
        int          plot;
        logic [1:0]  mo;
        logic [31:0] t;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 3) begin
                t = ($urandom_range(0, 4) == 0) ? $urandom : next_ms();
                sim_ms = t;
                push_sample(t, 2'($urandom_range(0, 3)), 16'($urandom), $urandom,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
                left--;
            end else begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len && left > 0; k++) begin
                    push_sample(next_ms(), mpm_pkg::MOTION_IDLE, 16'($urandom), enc_pos,
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
                    left--;
                end
                mo   = $urandom_range(0, 1) ? mpm_pkg::MOTION_OPENING
                                            : mpm_pkg::MOTION_CLOSING;
                plot = $urandom_range(PLOT_HEALTHY, PLOT_MIXED);
                len  = $urandom_range(4, 30);
                for (k = 0; k < len && left > 0; k++) begin
                    queue_motion(mo, plot);
                    left--;
                end
            end
        end
    endtask

    task automatic poke_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        cfg_val[idx] = val;     // block is idle, so the shadow may follow at once
    endtask

    task automatic program_regs(input logic [15:0] mc, input logic [15:0] zc,
                                input logic [15:0] et, input logic [15:0] mp,
                                input logic [15:0] cp, input logic [15:0] bl);
        poke_reg(mpm_pkg::CFG_MIN_CURRENT, mc);
        poke_reg(mpm_pkg::CFG_ZC_TIMEOUT, zc);
        poke_reg(mpm_pkg::CFG_ENC_TIMEOUT, et);
        poke_reg(mpm_pkg::CFG_MIN_PULSES, mp);
        poke_reg(mpm_pkg::CFG_CHECK_PERIOD, cp);
        poke_reg(mpm_pkg::CFG_BLANKING, bl);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Wait until every queued request went in and every verdict came out,
    // then let the pipe run empty.
    task automatic settle();
        while (sample_queue.size() != 0 || due_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick16(input int unsigned hi);
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, hi));
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed, reset thresholds: period 50, blanking 500, zero-current
        // timeout 800, pulse window 700, two steps, 150 mA.
        push_sample(32'd0, mpm_pkg::MOTION_IDLE,
                    16'd0, 32'd0, 1'b0, 1'b0, 1'b0);                 // too soon
        push_sample(32'd50, 2'd3,
                    16'hFFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1);      // code 3 = idle
        // opening, encoder stuck, near the open end
        push_sample(32'd400, mpm_pkg::MOTION_OPENING,
                    16'hFFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
        push_sample(32'd750, mpm_pkg::MOTION_OPENING,
                    16'hFFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
        push_sample(32'd1100, mpm_pkg::MOTION_OPENING,
                    16'hFFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
        // closing, stuck, near the closed end
        push_sample(32'd1450, mpm_pkg::MOTION_CLOSING,
                    16'd1000, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
        push_sample(32'd1800, mpm_pkg::MOTION_CLOSING,
                    16'd1000, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
        push_sample(32'd2150, mpm_pkg::MOTION_CLOSING,
                    16'd1000, 32'h8000_0000, 1'b1, 1'b0, 1'b1);
        // closing, stuck, away from the end
        push_sample(32'd2500, mpm_pkg::MOTION_CLOSING,
                    16'd1000, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
        push_sample(32'd2850, mpm_pkg::MOTION_CLOSING,
                    16'd1000, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
        push_sample(32'd3200, mpm_pkg::MOTION_CLOSING,
                    16'd1000, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
        // no current after blanking, current exactly at the threshold when it times out
        push_sample(32'd3250, mpm_pkg::MOTION_IDLE,
                    16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        push_sample(32'd3300, mpm_pkg::MOTION_OPENING,
                    16'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        push_sample(32'd4000, mpm_pkg::MOTION_OPENING,
                    16'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        push_sample(32'd4800, mpm_pkg::MOTION_OPENING,
                    16'd150, 32'd0, 1'b1, 1'b0, 1'b0);
        push_sample(32'd4820, mpm_pkg::MOTION_OPENING,
                    16'd151, 32'd3, 1'b1, 1'b0, 1'b0);
        // time wrapping through zero, encoder off then healthy
        push_sample(32'hFFFF_FFC0, mpm_pkg::MOTION_OPENING,
                    16'd151, 32'd5, 1'b0, 1'b1, 1'b1);
        push_sample(32'h0000_0010, mpm_pkg::MOTION_OPENING,
                    16'd151, 32'd7, 1'b1, 1'b1, 1'b1);
        // big signed encoder swing in one step
        push_sample(32'h0000_0070, mpm_pkg::MOTION_CLOSING,
                    16'd400, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1);
        push_sample(32'hFFFF_FFFF, mpm_pkg::MOTION_IDLE,
                    16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        push_sample(32'h7FFF_FFFF, mpm_pkg::MOTION_IDLE,
                    16'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
        sim_ms  = 32'h7FFF_FFFF;
        enc_pos = 32'h8000_0000;
        queue_traffic(400);
        settle();

        // lowest settings: every sample evaluated, instant timeouts
        program_regs(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0);
        queue_traffic(300);
        settle();

        // highest settings
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_traffic(250);
        settle();

        // zero step requirement: the pulse window can never expire
        program_regs(pick16(2000), pick16(3000), pick16(3000), 16'd0, pick16(200),
                     pick16(1500));
        queue_traffic(250);
        settle();

        repeat (3) begin
            program_regs(pick16(2000), pick16(3000), pick16(3000),
                         ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                                     : 16'($urandom_range(1, 20)),
                         pick16(200), pick16(1500));
            queue_traffic(250);
            settle();
        end

        repeat (8) @(negedge i_clk);
        $display("Ran %0d samples over %0d threshold settings; %0d verdicts, %0d evaluated",
                 n_samples, n_settings, n_verdicts, n_checked);
        $display("Actions seen: none %0d, no current %0d, no pulses %0d, %s %0d, %s %0d",
                 act_tally[mpm_pkg::ACT_NONE], act_tally[mpm_pkg::ACT_NO_CURRENT],
                 act_tally[mpm_pkg::ACT_NO_PULSES],
                 "open end", act_tally[mpm_pkg::ACT_OPEN_END],
                 "closed end", act_tally[mpm_pkg::ACT_CLOSED_END]);
        if (mismatch_count == 0 && due_verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ motor_plausibility_monitor.f @@
sv/mpm_pkg.sv
sv/motor_plausibility_monitor.sv
tb/tb.sv
